// ----- rtl/core/alm_pkg.sv -----
package alm_pkg;

    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IDX_W   = 6;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [2:0] ST_ADDED       = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_REMOVED     = 3'd2;
    localparam logic [2:0] ST_REMOVE_MISS = 3'd3;
    localparam logic [2:0] ST_FOUND       = 3'd4;
    localparam logic [2:0] ST_SEARCH_MISS = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_value;
        logic               last;
        logic [6:0]         pair_count;
    } t_rsp;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_FREE,
        CMD_START_WALK,
        CMD_READ_SLOT,
        CMD_STEP,
        CMD_ADD_COMMIT,
        CMD_REM_COMMIT,
        CMD_EMIT,
        CMD_EMIT_LAST,
        CMD_EMIT_MISS,
        CMD_EMIT_FULL
    } t_cmd;

    typedef struct packed {
        logic free_found;
        logic free_done;
        logic walk_done;
        logic match;
        logic full;
        logic empty;
        logic found_any;
    } t_stat;

endpackage

// ----- rtl/core/alm_datapath.sv -----
module alm_datapath #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  alm_pkg::t_cmd i_cmd,
    input  alm_pkg::t_req i_req,
    output alm_pkg::t_stat o_stat,
    output alm_pkg::t_rsp o_rsp
);

    localparam int unsigned IW = alm_pkg::IDX_W;
    localparam int unsigned CW = alm_pkg::CNT_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [31:0]   r_mkey [CAPACITY];
    logic [31:0]   r_mval [CAPACITY];
    logic [IW-1:0] r_mnext [CAPACITY];
    logic [IW-1:0] r_mprev [CAPACITY];
    logic [CAPACITY-1:0] r_used;
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;

    alm_pkg::t_req r_req;
    logic [IW-1:0] r_cur;
    logic [CW-1:0] r_steps;
    logic [IW-1:0] r_free;
    logic [CW-1:0] r_scan;
    logic [IW-1:0] r_tail;
    logic          r_found;
    logic [31:0]   r_pval;
    logic [31:0]   r_rkey;
    logic [31:0]   r_rval;
    logic [IW-1:0] r_rnext;
    logic [IW-1:0] r_rprev;

    logic cur_ok;
    logic key_eq;
    logic pair_eq;
    logic is_head;
    logic is_tail;
    logic nx_ok;
    logic pv_ok;

    logic          nxt_we;
    logic [IW-1:0] nxt_addr;
    logic [IW-1:0] nxt_data;
    logic          prv_we;
    logic [IW-1:0] prv_addr;
    logic [IW-1:0] prv_data;

    always_comb begin
        cur_ok  = ({1'b0, r_cur} < CAP);
        key_eq  = (r_rkey == r_req.key);
        pair_eq = key_eq && (r_rval == r_req.value);
        is_head = (r_steps == '0);
        is_tail = (r_steps + CW'(1) == r_count);
        nx_ok   = ({1'b0, r_rnext} < CAP);
        pv_ok   = ({1'b0, r_rprev} < CAP);
        o_stat.free_found = (r_scan < CAP) && !r_used[r_scan[IW-1:0]];
        o_stat.free_done  = (r_scan >= CAP);
        o_stat.walk_done  = (r_steps >= r_count) || !cur_ok;
        o_stat.match      = (r_req.req_type == alm_pkg::REQ_REMOVE) ? pair_eq : key_eq;
        o_stat.full       = (r_count >= CAP);
        o_stat.empty      = (r_count == '0);
        o_stat.found_any  = r_found;
    end

    always_comb begin
        nxt_we   = 1'b0;
        nxt_addr = r_rprev;
        nxt_data = r_rnext;
        prv_we   = 1'b0;
        prv_addr = r_rnext;
        prv_data = r_rprev;
        if (i_cmd == alm_pkg::CMD_ADD_COMMIT) begin
            nxt_we   = 1'b1;
            nxt_addr = (r_count == '0) ? r_free : r_tail;
            nxt_data = (r_count == '0) ? '0 : r_free;
            prv_we   = 1'b1;
            prv_addr = r_free;
            prv_data = (r_count == '0) ? '0 : r_tail;
        end else if (i_cmd == alm_pkg::CMD_REM_COMMIT && !is_head && pv_ok) begin
            nxt_we = 1'b1;
            prv_we = !is_tail && nx_ok;
        end
    end

    always_comb begin
        o_rsp            = '0;
        o_rsp.last       = 1'b1;
        o_rsp.pair_count = r_count;
        unique case (i_cmd)
            alm_pkg::CMD_ADD_COMMIT: begin
                o_rsp.status     = alm_pkg::ST_ADDED;
                o_rsp.pair_count = r_count + CW'(1);
            end
            alm_pkg::CMD_REM_COMMIT: begin
                o_rsp.status     = alm_pkg::ST_REMOVED;
                o_rsp.pair_count = r_count - CW'(1);
            end
            alm_pkg::CMD_EMIT: begin
                o_rsp.status      = alm_pkg::ST_FOUND;
                o_rsp.found_value = r_pval;
                o_rsp.last        = 1'b0;
            end
            alm_pkg::CMD_EMIT_LAST: begin
                o_rsp.status      = alm_pkg::ST_FOUND;
                o_rsp.found_value = r_pval;
            end
            alm_pkg::CMD_EMIT_MISS: begin
                o_rsp.status = (r_req.req_type == alm_pkg::REQ_REMOVE) ?
                               alm_pkg::ST_REMOVE_MISS : alm_pkg::ST_SEARCH_MISS;
            end
            alm_pkg::CMD_EMIT_FULL: begin
                o_rsp.status = alm_pkg::ST_FULL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == alm_pkg::CMD_READ_SLOT) begin
            r_rkey  <= r_mkey[r_cur];
            r_rval  <= r_mval[r_cur];
            r_rnext <= r_mnext[r_cur];
            r_rprev <= r_mprev[r_cur];
        end
        if (i_cmd == alm_pkg::CMD_ADD_COMMIT) begin
            r_mkey[r_free] <= r_req.key;
            r_mval[r_free] <= r_req.value;
        end
        if (nxt_we) begin
            r_mnext[nxt_addr] <= nxt_data;
        end
        if (prv_we) begin
            r_mprev[prv_addr] <= prv_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (i_cmd)
                alm_pkg::CMD_LOAD: begin
                    r_req   <= i_req;
                    r_scan  <= '0;
                    r_found <= 1'b0;
                end
                alm_pkg::CMD_SCAN_FREE: begin
                    r_free <= r_scan[IW-1:0];
                    r_scan <= r_scan + CW'(1);
                end
                alm_pkg::CMD_START_WALK: begin
                    r_cur   <= r_head;
                    r_tail  <= r_head;
                    r_steps <= '0;
                end
                alm_pkg::CMD_STEP: begin
                    r_tail  <= r_cur;
                    r_cur   <= r_rnext;
                    r_steps <= r_steps + CW'(1);
                end
                alm_pkg::CMD_ADD_COMMIT: begin
                    r_used[r_free] <= 1'b1;
                    if (r_count == '0) begin
                        r_head <= r_free;
                    end
                    r_count <= r_count + CW'(1);
                end
                alm_pkg::CMD_REM_COMMIT: begin
                    r_used[r_cur] <= 1'b0;
                    r_count       <= r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        r_head <= '0;
                    end else if (is_head && !is_tail && nx_ok) begin
                        r_head <= r_rnext;
                    end
                end
                alm_pkg::CMD_EMIT: begin
                    r_found <= 1'b1;
                    r_pval  <= r_rval;
                    r_tail  <= r_cur;
                    r_cur   <= r_rnext;
                    r_steps <= r_steps + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/alm_ctrl.sv -----
module alm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic [1:0]     i_req_type,
    input  alm_pkg::t_stat i_stat,
    output alm_pkg::t_cmd  o_cmd,
    output logic           o_load
);

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_WALK_RD, S_WALK_CHK,
        S_COMMIT_ADD, S_OUT, S_OUT_SEARCH
    } t_state;

    t_state        r_state;
    logic [1:0]    r_type;
    logic          r_hold;
    logic          taken;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_hold;
    assign taken       = r_hold && i_out_ready;

    always_comb begin
        o_cmd  = alm_pkg::CMD_NONE;
        o_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = alm_pkg::CMD_LOAD;
                end
            end
            S_DISPATCH: begin
                if (r_type == alm_pkg::REQ_ADD && i_stat.full) begin
                    o_cmd  = alm_pkg::CMD_EMIT_FULL;
                    o_load = 1'b1;
                end else begin
                    o_cmd = alm_pkg::CMD_START_WALK;
                end
            end
            S_SCAN: begin
                if (i_stat.free_done) begin
                    o_cmd  = alm_pkg::CMD_EMIT_FULL;
                    o_load = 1'b1;
                end else begin
                    o_cmd = alm_pkg::CMD_SCAN_FREE;
                end
            end
            S_WALK_RD: begin
                if (!i_stat.walk_done) begin
                    o_cmd = alm_pkg::CMD_READ_SLOT;
                end else if (r_type == alm_pkg::REQ_REMOVE) begin
                    o_cmd  = alm_pkg::CMD_EMIT_MISS;
                    o_load = 1'b1;
                end else if (r_type == alm_pkg::REQ_SEARCH) begin
                    o_cmd  = i_stat.found_any ? alm_pkg::CMD_EMIT_LAST : alm_pkg::CMD_EMIT_MISS;
                    o_load = 1'b1;
                end
            end
            S_WALK_CHK: begin
                if (r_type != alm_pkg::REQ_ADD && i_stat.match) begin
                    if (r_type == alm_pkg::REQ_REMOVE) begin
                        o_cmd  = alm_pkg::CMD_REM_COMMIT;
                        o_load = 1'b1;
                    end else begin
                        o_cmd  = alm_pkg::CMD_EMIT;
                        o_load = i_stat.found_any;
                    end
                end else begin
                    o_cmd = alm_pkg::CMD_STEP;
                end
            end
            S_COMMIT_ADD: begin
                o_cmd  = alm_pkg::CMD_ADD_COMMIT;
                o_load = 1'b1;
            end
            S_OUT, S_OUT_SEARCH: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_type  <= alm_pkg::REQ_ADD;
            r_hold  <= 1'b0;
        end else begin
            if (o_load) begin
                r_hold <= 1'b1;
            end else if (taken) begin
                r_hold <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_type  <= i_req_type;
                        r_state <= (i_req_type == alm_pkg::REQ_NONE) ? S_IDLE : S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    if (r_type == alm_pkg::REQ_ADD && i_stat.full) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= (r_type == alm_pkg::REQ_ADD) ? S_SCAN : S_WALK_RD;
                    end
                end
                S_SCAN: begin
                    if (i_stat.free_done) begin
                        r_state <= S_OUT;
                    end else if (i_stat.free_found) begin
                        r_state <= (i_stat.empty) ? S_COMMIT_ADD : S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    if (!i_stat.walk_done) begin
                        r_state <= S_WALK_CHK;
                    end else if (r_type == alm_pkg::REQ_ADD) begin
                        r_state <= S_COMMIT_ADD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_WALK_CHK: begin
                    if (r_type != alm_pkg::REQ_ADD && i_stat.match) begin
                        if (r_type == alm_pkg::REQ_REMOVE) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= i_stat.found_any ? S_OUT_SEARCH : S_WALK_RD;
                        end
                    end else begin
                        r_state <= S_WALK_RD;
                    end
                end
                S_COMMIT_ADD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (taken) begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT_SEARCH: begin
                    if (taken) begin
                        r_state <= S_WALK_RD;
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/alm_outbuf.sv -----
module alm_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  alm_pkg::t_rsp i_rsp,
    output alm_pkg::t_rsp o_rsp
);

    alm_pkg::t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp <= '0;
        end else if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- rtl/core/array_linked_multimap.sv -----
// Channel | Direction | Handshake               | Word
// in      | input     | i_in_valid/o_in_ready   | t_req
// out     | output    | o_out_valid/i_out_ready | t_rsp
// The chain walk reads each slot in state S_WALK_RD and checks it in S_WALK_CHK.
// An add first scans the used map one slot a cycle for the lowest free slot.
// Each search match after the first sends out the previous match; the last one goes out with last set.
// Reset is synchronous; the used map, head and count clear at once.
// A stalled output holds the walk until the word is taken.
module array_linked_multimap #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  alm_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output alm_pkg::t_rsp o_out_data
);

    alm_pkg::t_cmd  cmd;
    alm_pkg::t_stat stat;
    alm_pkg::t_rsp  dp_rsp;
    logic           load;

    alm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_req_type  (i_in_data.req_type),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_load      (load)
    );

    alm_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_stat  (stat),
        .o_rsp   (dp_rsp)
    );

    alm_outbuf u_ob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_rsp   (dp_rsp),
        .o_rsp   (o_out_data)
    );

endmodule

// ----- rtl/core/alm_checker.sv -----
module alm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input alm_pkg::t_rsp o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word dropped while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= alm_pkg::ST_SEARCH_MISS)
        else $error("bad status");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pair_count <= 7'd64)
        else $error("count out of range");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != alm_pkg::ST_FOUND |-> o_out_data.last)
        else $error("non-search result without last");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a word is pending");

endmodule

bind array_linked_multimap alm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
